### rtl/core/sgsf_pkg.sv
// Shared types and constants for the Savitzky-Golay slope filter.
// No dependencies; used by every module of the filter.
package sgsf_pkg;

  localparam int DEFAULT_SAMPLE_WIDTH = 16;
  localparam int TAP_COUNT = 5;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE = 2'd1;
  localparam logic [1:0] SEEN_FULL = 2'd2;

  localparam logic [2:0] CENTER_LEFT = 3'd2;
  localparam logic [2:0] CENTER_MID = 3'd3;
  localparam logic [2:0] CENTER_RIGHT = 3'd4;

  typedef struct packed {
    logic [2:0] first_center;
    logic       last_trace;
  } ctl_t;

endpackage

### rtl/core/sgsf_front.sv
// Front end: accepts samples, keeps the sample window and trace position,
// and builds one queue entry per sample that yields results. Uses sgsf_pkg.
module sgsf_front #(
  parameter int SAMPLE_WIDTH = sgsf_pkg::DEFAULT_SAMPLE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           final_sample,
  input  logic                           q_full,
  output logic                           push,
  output logic signed [SAMPLE_WIDTH-1:0] taps [sgsf_pkg::TAP_COUNT],
  output sgsf_pkg::ctl_t                 ctl
);
  import sgsf_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] window [TAP_COUNT-1];
  logic [1:0] seen_count;
  logic [1:0] seen_count_next;
  logic accept;

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;
  assign push = accept && (final_sample || (seen_count == SEEN_FULL));

  always_comb begin
    for (int i = 0; i < TAP_COUNT - 1; i++) begin
      taps[i] = (seen_count == SEEN_NONE) ? sample : window[TAP_COUNT - 2 - i];
    end
    taps[TAP_COUNT-1] = sample;
    ctl.last_trace = final_sample;
    if (seen_count == SEEN_FULL) begin
      ctl.first_center = CENTER_LEFT;
    end else if (seen_count == SEEN_ONE) begin
      ctl.first_center = CENTER_MID;
    end else begin
      ctl.first_center = CENTER_RIGHT;
    end
  end

  always_comb begin
    if (final_sample) begin
      seen_count_next = SEEN_NONE;
    end else if (seen_count == SEEN_FULL) begin
      seen_count_next = SEEN_FULL;
    end else begin
      seen_count_next = seen_count + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count <= SEEN_NONE;
    end else if (accept) begin
      seen_count <= seen_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      window[0] <= sample;
      for (int i = 1; i < TAP_COUNT - 1; i++) begin
        window[i] <= (seen_count == SEEN_NONE) ? sample : window[i-1];
      end
    end
  end

endmodule

### rtl/core/sgsf_queue.sv
// Entry queue between front and back ends: tap sets plus control fields.
// Depth is a power of two from sgsf_pkg.
module sgsf_queue #(
  parameter int SAMPLE_WIDTH = sgsf_pkg::DEFAULT_SAMPLE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic signed [SAMPLE_WIDTH-1:0] push_taps [sgsf_pkg::TAP_COUNT],
  input  sgsf_pkg::ctl_t                 push_ctl,
  input  logic                           pop,
  output logic                           q_valid,
  output logic                           q_full,
  output logic signed [SAMPLE_WIDTH-1:0] head_taps [sgsf_pkg::TAP_COUNT],
  output sgsf_pkg::ctl_t                 head_ctl
);
  import sgsf_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

  logic signed [SAMPLE_WIDTH-1:0] tap_mem [QUEUE_DEPTH][TAP_COUNT];
  ctl_t ctl_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_valid = (count != '0);
  assign q_full = (count == FULL_COUNT);
  assign head_taps = tap_mem[rd_ptr];
  assign head_ctl = ctl_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      tap_mem[wr_ptr] <= push_taps;
      ctl_mem[wr_ptr] <= push_ctl;
    end
  end

endmodule

### rtl/core/sgsf_back.sv
// Back end: steps through the result centers of the head entry, computes
// 2*(a-e)+(b-d) and holds each result in the output register. Uses sgsf_pkg.
module sgsf_back #(
  parameter int SAMPLE_WIDTH = sgsf_pkg::DEFAULT_SAMPLE_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  logic signed [SAMPLE_WIDTH-1:0]   head_taps [sgsf_pkg::TAP_COUNT],
  input  sgsf_pkg::ctl_t                   head_ctl,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [SAMPLE_WIDTH+2:0]   slope_tenths,
  output logic                             final_result
);
  import sgsf_pkg::*;

  localparam int OUT_WIDTH = SAMPLE_WIDTH + 3;

  logic [1:0] sub;
  logic [2:0] center;
  logic issue;
  logic entry_done;
  logic signed [SAMPLE_WIDTH-1:0] tap_a;
  logic signed [SAMPLE_WIDTH-1:0] tap_b;
  logic signed [SAMPLE_WIDTH-1:0] tap_d;
  logic signed [SAMPLE_WIDTH-1:0] tap_e;
  logic signed [SAMPLE_WIDTH:0] diff_far;
  logic signed [SAMPLE_WIDTH:0] diff_near;
  logic signed [OUT_WIDTH-1:0] slope_next;

  assign center = head_ctl.first_center + {1'b0, sub};
  assign entry_done = !head_ctl.last_trace || (center == CENTER_RIGHT);
  assign issue = q_valid && (!out_valid || out_ready);
  assign pop = issue && entry_done;

  always_comb begin
    unique case (center)
      CENTER_LEFT: begin
        tap_a = head_taps[0];
        tap_b = head_taps[1];
        tap_d = head_taps[3];
        tap_e = head_taps[4];
      end
      CENTER_MID: begin
        tap_a = head_taps[1];
        tap_b = head_taps[2];
        tap_d = head_taps[4];
        tap_e = head_taps[4];
      end
      default: begin
        tap_a = head_taps[2];
        tap_b = head_taps[3];
        tap_d = head_taps[4];
        tap_e = head_taps[4];
      end
    endcase
  end

  assign diff_far = {tap_a[SAMPLE_WIDTH-1], tap_a} - {tap_e[SAMPLE_WIDTH-1], tap_e};
  assign diff_near = {tap_b[SAMPLE_WIDTH-1], tap_b} - {tap_d[SAMPLE_WIDTH-1], tap_d};
  assign slope_next = {diff_far[SAMPLE_WIDTH], diff_far, 1'b0}
                    + {{2{diff_near[SAMPLE_WIDTH]}}, diff_near};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub <= 2'd0;
    end else begin
      if (issue) begin
        out_valid <= 1'b1;
        sub <= entry_done ? 2'd0 : sub + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      slope_tenths <= slope_next;
      final_result <= head_ctl.last_trace && (center == CENTER_RIGHT);
    end
  end

endmodule

### rtl/core/savitzky_golay_slope_filter.sv
// Results of a sample pass through the entry queue into the output register.
// Samples are accepted one per cycle while the queue is not full; a final
// sample yields up to three results, one per center, buffered by a
// four-entry queue. Reset clears the trace position, the queue and the
// output valid; the sample window needs no reset.
module savitzky_golay_slope_filter #(
  parameter int SAMPLE_WIDTH = sgsf_pkg::DEFAULT_SAMPLE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           final_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH+2:0] slope_tenths,
  output logic                           final_result
);
  import sgsf_pkg::*;

  logic push;
  logic pop;
  logic q_valid;
  logic q_full;
  logic signed [SAMPLE_WIDTH-1:0] push_taps [TAP_COUNT];
  logic signed [SAMPLE_WIDTH-1:0] head_taps [TAP_COUNT];
  ctl_t push_ctl;
  ctl_t head_ctl;

  sgsf_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample(sample),
    .final_sample(final_sample),
    .q_full(q_full),
    .push(push),
    .taps(push_taps),
    .ctl(push_ctl)
  );

  sgsf_queue #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_taps(push_taps),
    .push_ctl(push_ctl),
    .pop(pop),
    .q_valid(q_valid),
    .q_full(q_full),
    .head_taps(head_taps),
    .head_ctl(head_ctl)
  );

  sgsf_back #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .head_taps(head_taps),
    .head_ctl(head_ctl),
    .pop(pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .slope_tenths(slope_tenths),
    .final_result(final_result)
  );

endmodule

### dv/slope_checker.sv
// Scoreboard for the Savitzky-Golay slope filter: watches both channels, predicts
// every slope from the accepted samples and compares it with what leaves the block.
// Depends on sgsf_pkg for the trace position and window center codes.
module slope_checker #(
  parameter int SAMPLE_WIDTH = sgsf_pkg::DEFAULT_SAMPLE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           final_sample,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic signed [SAMPLE_WIDTH+2:0] slope_tenths,
  input  logic                           final_result,
  output int                             error_count,
  output int                             pending_slopes
);
  import sgsf_pkg::*;

  localparam int WINDOW_DEPTH = TAP_COUNT - 1;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    logic signed [SAMPLE_WIDTH+2:0] slope;
    logic                           last;
  } slope_expect_t;

  slope_expect_t expected_slopes[$];
  longint        trace_win[WINDOW_DEPTH];
  logic [1:0]    trace_pos;

  initial begin
    error_count = 0;
    pending_slopes = 0;
  end

  task automatic report_mismatch(input string what);
    if (error_count < MAX_REPORTS) begin
      $display("slope_checker: mismatch at %0t: %s", $time, what);
    end
    error_count++;
  endtask

  function automatic longint slope_at(input longint taps[7], input int c);
    return 2 * (taps[c-2] - taps[c+2]) + (taps[c-1] - taps[c+1]);
  endfunction

  task automatic queue_slope(input longint value, input logic last);
    slope_expect_t e;
    e.slope = value[SAMPLE_WIDTH+2:0];
    e.last = last;
    expected_slopes.push_back(e);
  endtask

  task automatic predict_slopes(input logic signed [SAMPLE_WIDTH-1:0] x, input logic last);
    longint     taps[7];
    logic [2:0] first_center;
    if (trace_pos == SEEN_NONE) begin
      foreach (trace_win[i]) trace_win[i] = x;
    end
    taps[0] = trace_win[3];
    taps[1] = trace_win[2];
    taps[2] = trace_win[1];
    taps[3] = trace_win[0];
    taps[4] = x;
    taps[5] = x;
    taps[6] = x;
    if (last) begin
      if (trace_pos >= SEEN_FULL) begin
        first_center = CENTER_LEFT;
      end else if (trace_pos == SEEN_ONE) begin
        first_center = CENTER_MID;
      end else begin
        first_center = CENTER_RIGHT;
      end
      for (int c = first_center; c <= CENTER_RIGHT; c++) begin
        queue_slope(slope_at(taps, c), c == CENTER_RIGHT);
      end
      trace_pos = SEEN_NONE;
    end else if (trace_pos >= SEEN_FULL) begin
      queue_slope(slope_at(taps, CENTER_LEFT), 1'b0);
    end else begin
      trace_pos++;
    end
    for (int i = WINDOW_DEPTH - 1; i > 0; i--) trace_win[i] = trace_win[i-1];
    trace_win[0] = x;
  endtask

  always @(posedge clk) begin : watch
    slope_expect_t head;
    if (rst) begin
      expected_slopes.delete();
      trace_pos = SEEN_NONE;
      foreach (trace_win[i]) trace_win[i] = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_slopes.size() == 0) begin
          report_mismatch($sformatf("unexpected slope %0d", slope_tenths));
        end else begin
          head = expected_slopes.pop_front();
          if (slope_tenths !== head.slope) begin
            report_mismatch($sformatf("slope_tenths %0d, expected %0d",
                                      slope_tenths, head.slope));
          end
          if (final_result !== head.last) begin
            report_mismatch($sformatf("final_result %b, expected %b",
                                      final_result, head.last));
          end
        end
      end
      if (in_valid && in_ready) predict_slopes(sample, final_sample);
    end
    pending_slopes = expected_slopes.size();
  end

endmodule

### dv/savitzky_golay_slope_filter_tb.sv
// Top of the slope filter testbench: clock, reset, sample traces and output stalls.
// Instantiates savitzky_golay_slope_filter and slope_checker; uses sgsf_pkg.
module savitzky_golay_slope_filter_tb;
  import sgsf_pkg::*;

  localparam int SW = DEFAULT_SAMPLE_WIDTH;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int TOTAL_ITEMS = 420;
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};

  typedef enum logic [1:0] {STYLE_FULL, STYLE_NARROW, STYLE_EXTREME} sample_style_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [SW-1:0] sample;
  logic                 final_sample;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [SW+2:0] slope_tenths;
  logic                 final_result;
  int                   error_count;
  int                   pending_slopes;
  int                   cycle_count;
  int                   items_sent;
  bit                   tx_idle_en;
  bit                   rx_idle_en;
  bit                   long_hold_req;

  savitzky_golay_slope_filter #(.SAMPLE_WIDTH(SW)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample       (sample),
    .final_sample (final_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .slope_tenths (slope_tenths),
    .final_result (final_result)
  );

  slope_checker #(.SAMPLE_WIDTH(SW)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("savitzky_golay_slope_filter_tb: FAIL");
    $finish;
  end

  function automatic logic signed [SW-1:0] draw_sample(input sample_style_t style);
    int v;
    case (style)
      STYLE_NARROW: v = int'($urandom_range(0, 15)) - 8;
      STYLE_EXTREME: v = $urandom_range(0, 1) ? S_MAX : S_MIN;
      default: v = $urandom;
    endcase
    return SW'(v);
  endfunction

  task automatic send_sample(input logic signed [SW-1:0] value, input logic last);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= value;
    final_sample <= last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_random_trace();
    int            len;
    int            roll;
    sample_style_t style;
    roll = $urandom_range(0, 9);
    if (roll < 2) begin
      len = $urandom_range(1, 2);
    end else if (roll < 9) begin
      len = $urandom_range(3, 16);
    end else begin
      len = $urandom_range(17, 48);
    end
    style = sample_style_t'($urandom_range(0, 2));
    for (int i = 0; i < len; i++) send_sample(draw_sample(style), i == len - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_slopes != 0);
  endtask

  // output side: random stall per transaction, one long hold on request
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        stall = LONG_HOLD_CYCLES;
        long_hold_req = 1'b0;
      end else begin
        stall = rx_idle_en ? $urandom_range(0, 7) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    sample <= '0;
    final_sample <= 1'b0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    long_hold_req = 1'b0;
    items_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_sample(S_MIN, 1'b1);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b1);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b1);
    for (int i = 0; i < 6; i++) send_sample((i % 2) ? S_MIN : S_MAX, i == 5);
    send_sample('0, 1'b0);
    send_sample({(SW/2){2'b01}}, 1'b0);
    send_sample({(SW/2){2'b10}}, 1'b0);
    send_sample('0, 1'b0);
    send_sample('1, 1'b1);

    while (items_sent < 150) send_random_trace();
    wait_drained();

    // hold the output side while samples keep coming
    long_hold_req = 1'b1;
    tx_idle_en = 1'b0;
    while (items_sent < 210) send_random_trace();
    tx_idle_en = 1'b1;

    rx_idle_en = 1'b0;
    tx_idle_en = 1'b0;
    while (items_sent < 290) send_random_trace();
    rx_idle_en = 1'b1;
    tx_idle_en = 1'b1;

    while (items_sent < TOTAL_ITEMS) send_random_trace();
    in_valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);

    if (error_count == 0) begin
      $display("savitzky_golay_slope_filter_tb: PASS");
    end else begin
      $display("savitzky_golay_slope_filter_tb: FAIL");
    end
    $finish;
  end

endmodule

### savitzky_golay_slope_filter.f
rtl/core/sgsf_pkg.sv
rtl/core/sgsf_front.sv
rtl/core/sgsf_queue.sv
rtl/core/sgsf_back.sv
rtl/core/savitzky_golay_slope_filter.sv
dv/slope_checker.sv
dv/savitzky_golay_slope_filter_tb.sv
